### hdl/dns_pkg.sv
`default_nettype none
package dns_pkg;

	// Table geometry
	localparam int MAX_WINDOWS = 16;
	localparam int IDX_W       = $clog2(MAX_WINDOWS);
	localparam int CNT_W       = 5;
	localparam int ENTRY_W     = 62;
	// Edges reach x + w, middles differ by up to about 82k
	localparam int EDGE_W      = 18;
	localparam int DIST_W      = 17;

	// Function codes
	localparam logic [1:0] FUNC_LOAD  = 2'd0;
	localparam logic [1:0] FUNC_NEXT  = 2'd1;
	localparam logic [1:0] FUNC_FIRST = 2'd2;

	// Configuration register indexes
	localparam int         CFG_IDX_W  = 2;
	localparam int         CFG_DATA_W = 5;
	localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd1;

	typedef enum logic [1:0] {
		DIR_LEFT  = 2'd0,
		DIR_UP    = 2'd1,
		DIR_RIGHT = 2'd2,
		DIR_DOWN  = 2'd3
	} dir_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_P1,
		ST_P2,
		ST_FIN,
		ST_DONE
	} state_t;

	// What a table read is for
	typedef enum logic [1:0] {
		RD_NONE,
		RD_CUR,
		RD_P1,
		RD_P2
	} rd_kind_t;

	typedef struct packed {
		rd_kind_t rd_kind;
		logic     idx_clr;
		logic     idx_inc;
	} dns_cmd_t;

	typedef struct packed {
		logic skip;
		logic last;
	} dns_stat_t;

	typedef struct packed {
		logic        [14:0] h;
		logic        [14:0] w;
		logic signed [15:0] y;
		logic signed [15:0] x;
	} rect_t;

	typedef logic signed [EDGE_W-1:0] edge_t;

	// Horizontal middle, x + w/2 truncated
	function automatic edge_t hmid(rect_t b);
		edge_t xe;
		edge_t we;
		xe = EDGE_W'(b.x);
		we = signed'(EDGE_W'(b.w));
		return xe + (we >>> 1);
	endfunction

	function automatic edge_t vmid(rect_t b);
		edge_t ye;
		edge_t he;
		ye = EDGE_W'(b.y);
		he = signed'(EDGE_W'(b.h));
		return ye + (he >>> 1);
	endfunction

	// Edge met first when traveling toward this rectangle
	function automatic edge_t near_edge(rect_t b, dir_t d, logic center);
		edge_t xe;
		edge_t ye;
		edge_t we;
		edge_t he;
		edge_t r;
		xe = EDGE_W'(b.x);
		ye = EDGE_W'(b.y);
		we = signed'(EDGE_W'(b.w));
		he = signed'(EDGE_W'(b.h));
		if (center) begin
			r = (d == DIR_LEFT || d == DIR_RIGHT) ? hmid(b) : vmid(b);
		end else begin
			unique case (d)
				DIR_LEFT:  r = xe + we;
				DIR_UP:    r = ye + he;
				DIR_RIGHT: r = xe;
				DIR_DOWN:  r = ye;
				default:   r = xe;
			endcase
		end
		return r;
	endfunction

	// Edge left behind when leaving this rectangle
	function automatic edge_t far_edge(rect_t b, dir_t d, logic center);
		edge_t xe;
		edge_t ye;
		edge_t we;
		edge_t he;
		edge_t r;
		xe = EDGE_W'(b.x);
		ye = EDGE_W'(b.y);
		we = signed'(EDGE_W'(b.w));
		he = signed'(EDGE_W'(b.h));
		if (center) begin
			r = (d == DIR_LEFT || d == DIR_RIGHT) ? hmid(b) : vmid(b);
		end else begin
			unique case (d)
				DIR_LEFT:  r = xe;
				DIR_UP:    r = ye;
				DIR_RIGHT: r = xe + we;
				DIR_DOWN:  r = ye + he;
				default:   r = xe;
			endcase
		end
		return r;
	endfunction

	function automatic edge_t cross_mid(rect_t b, dir_t d);
		return (d == DIR_LEFT || d == DIR_RIGHT) ? vmid(b) : hmid(b);
	endfunction

endpackage
`default_nettype wire

### hdl/dns_ram.sv
`default_nettype none
module dns_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

### hdl/dns_ctrl.sv
`default_nettype none
module dns_ctrl
	import dns_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire logic [1:0] func,
	input  wire dns_stat_t stat,
	output logic           busy,
	output logic           acc,
	output logic           done,
	output dns_cmd_t       cmd
);

	state_t state_q;
	state_t state_nxt;

	assign busy = (state_q != ST_IDLE);
	assign acc  = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && (func == FUNC_NEXT || func == FUNC_FIRST)) begin
					state_nxt = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_nxt = stat.skip ? ST_DONE : ST_P1;
			end
			ST_P1: begin
				if (stat.last) begin
					state_nxt = ST_P2;
				end
			end
			ST_P2: begin
				if (stat.last) begin
					state_nxt = ST_FIN;
				end
			end
			ST_FIN:  state_nxt = ST_DONE;
			ST_DONE: state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Outputs: each read is consumed by the datapath in the next cycle
	always_comb begin
		cmd  = '{rd_kind: RD_NONE, idx_clr: 1'b0, idx_inc: 1'b0};
		done = 1'b0;
		unique case (state_q)
			ST_IDLE: ;
			ST_CHECK: begin
				cmd.rd_kind = stat.skip ? RD_NONE : RD_CUR;
				cmd.idx_clr = 1'b1;
			end
			ST_P1: begin
				cmd.rd_kind = RD_P1;
				cmd.idx_clr = stat.last;
				cmd.idx_inc = ~stat.last;
			end
			ST_P2: begin
				cmd.rd_kind = RD_P2;
				cmd.idx_inc = ~stat.last;
			end
			ST_FIN: ;
			ST_DONE: done = 1'b1;
			default: ;
		endcase
	end

endmodule
`default_nettype wire

### hdl/dns_dp.sv
`default_nettype none
module dns_dp
	import dns_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  acc,
	input  wire logic [1:0]            func,
	input  wire logic [3:0]            slot,
	input  wire logic signed [15:0]    x_pos,
	input  wire logic signed [15:0]    y_pos,
	input  wire logic [14:0]           width,
	input  wire logic [14:0]           height,
	input  wire logic [1:0]            direction,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire dns_cmd_t              cmd,
	output dns_stat_t                  stat,
	output logic                       found,
	output logic [3:0]                 target_slot
);

	// Configuration
	logic             mode_q;
	logic [CNT_W-1:0] wcount_q;

	// Query context
	logic [IDX_W-1:0] slot_q;
	dir_t             dir_q;
	logic             wrap_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] idx_q;

	// Read pipeline
	rd_kind_t         kind_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [ENTRY_W-1:0] rdata;
	rect_t            rd_rect;

	// Search state
	edge_t             ref_q;
	edge_t             mid_q;
	edge_t             best_q;
	logic              have_best_q;
	logic [DIST_W-1:0] dist_q;
	logic [IDX_W-1:0]  win_q;
	logic              have_win_q;

	edge_t             n_edge;
	edge_t             f_edge;
	edge_t             c_mid;
	edge_t             diff;
	logic [DIST_W-1:0] cross_gap;
	logic              backward;
	logic              qual;
	logic              take_best;
	logic              take_win;
	rect_t             wr_rect;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			wcount_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:  mode_q   <= cfg_data[0];
				REG_COUNT: wcount_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Rectangle table
	assign wr_rect = '{h: height, w: width, y: y_pos, x: x_pos};

	dns_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_WINDOWS)
	) u_ram (
		.clk   (clk),
		.we    (acc && func == FUNC_LOAD),
		.waddr (slot),
		.wdata (wr_rect),
		.re    (cmd.rd_kind != RD_NONE),
		.raddr ((cmd.rd_kind == RD_CUR) ? slot_q : idx_q),
		.rdata (rdata)
	);

	assign rd_rect = rect_t'(rdata);

	// Latch query on accept, clamp count to table size
	always_ff @(posedge clk) begin
		if (acc) begin
			slot_q <= slot;
			dir_q  <= dir_t'(direction);
			wrap_q <= (func == FUNC_FIRST);
			cnt_q  <= (wcount_q > CNT_W'(MAX_WINDOWS)) ? CNT_W'(MAX_WINDOWS) : wcount_q;
		end
	end

	assign stat.skip = (cnt_q == '0) || ({1'b0, slot_q} >= cnt_q);
	assign stat.last = ({1'b0, idx_q} == (cnt_q - CNT_W'(1)));

	// Scan index and read tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			kind_s1 <= RD_NONE;
		end else begin
			kind_s1 <= cmd.rd_kind;
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
	end

	// Edge arithmetic on the word just read
	assign n_edge    = near_edge(rd_rect, dir_q, mode_q);
	assign f_edge    = far_edge(rd_rect, dir_q, mode_q);
	assign c_mid     = cross_mid(rd_rect, dir_q);
	assign diff      = c_mid - mid_q;
	assign cross_gap = diff[EDGE_W-1] ? DIST_W'(-diff) : DIST_W'(diff);
	assign backward  = (dir_q == DIR_LEFT) || (dir_q == DIR_UP);

	always_comb begin
		if (wrap_q) begin
			qual = 1'b1;
		end else if (backward) begin
			qual = mode_q ? (n_edge < ref_q) : (n_edge <= ref_q);
		end else begin
			qual = mode_q ? (n_edge > ref_q) : (n_edge >= ref_q);
		end
	end

	assign take_best = (kind_s1 == RD_P1) && qual &&
		(!have_best_q || (backward ? (n_edge > best_q) : (n_edge < best_q)));
	assign take_win  = (kind_s1 == RD_P2) && have_best_q && (n_edge == best_q) &&
		(!have_win_q || (cross_gap < dist_q));

	// Search flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_best_q <= 1'b0;
			have_win_q  <= 1'b0;
		end else if (acc) begin
			have_best_q <= 1'b0;
			have_win_q  <= 1'b0;
		end else begin
			if (take_best) begin
				have_best_q <= 1'b1;
			end
			if (take_win) begin
				have_win_q <= 1'b1;
			end
		end
	end

	// Search values
	always_ff @(posedge clk) begin
		if (kind_s1 == RD_CUR) begin
			ref_q <= f_edge;
			mid_q <= c_mid;
		end
		if (take_best) begin
			best_q <= n_edge;
		end
		if (take_win) begin
			dist_q <= cross_gap;
			win_q  <= idx_s1;
		end
	end

	assign found       = have_win_q;
	assign target_slot = have_win_q ? 4'(win_q) : 4'd0;

endmodule
`default_nettype wire

### hdl/directional_neighbor_select_core.sv
// Directional neighbor select.
// Keeps a table of up to 16 rectangles and picks the neighbor of a current
// rectangle in a given direction (left, up, right, down).
// Input: a word is taken when start is high and busy is low. func 0 loads
// x_pos/y_pos/width/height into slot at once and gives no result; func 1
// (next) and func 2 (first, wraps) query from slot toward direction.
// func 3 is taken and ignored.
// Config: cfg_valid/cfg_ready write cfg_data to register cfg_index
// (0 relation mode, 1 window count); cfg_ready is always high. Write only
// while busy is low.
// Result: each query yields one word; done is high for one cycle with
// found and target_slot valid. The receiver cannot stall the block.
// Flow: a query makes two passes over the table through its single read
// port; an empty table or out-of-range slot goes from the check straight
// to done. One query at a time.
// Reset: clears mode, count and control; table contents are undefined
// until loaded.
`default_nettype none
module directional_neighbor_select_core
	import dns_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [1:0]            func,
	input  wire logic [3:0]            slot,
	input  wire logic signed [15:0]    x_pos,
	input  wire logic signed [15:0]    y_pos,
	input  wire logic [14:0]           width,
	input  wire logic [14:0]           height,
	input  wire logic [1:0]            direction,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output logic                       done,
	output logic                       found,
	output logic [3:0]                 target_slot
);

	logic      acc;
	dns_cmd_t  cmd;
	dns_stat_t stat;

	assign cfg_ready = 1'b1;

	dns_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.stat   (stat),
		.busy   (busy),
		.acc    (acc),
		.done   (done),
		.cmd    (cmd)
	);

	dns_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.acc         (acc),
		.func        (func),
		.slot        (slot),
		.x_pos       (x_pos),
		.y_pos       (y_pos),
		.width       (width),
		.height      (height),
		.direction   (direction),
		.cfg_we      (cfg_valid & cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.stat        (stat),
		.found       (found),
		.target_slot (target_slot)
	);

endmodule
`default_nettype wire

### test/tb_directional_neighbor_select_core.sv
`timescale 1ns / 1ps

module tb_directional_neighbor_select_core;
	import dns_pkg::*;

	// func 3 is taken by the block and dropped
	localparam logic [1:0] FUNC_NOP = 2'd3;
	// idle time after draining, long enough for a full-table query
	localparam int SETTLE_CYCLES = 40;
	localparam int RUN_LIMIT_NS  = 4_000_000;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic        [14:0] w;
		logic        [14:0] h;
	} box_t;

	typedef struct {
		logic       found;
		logic [3:0] slot;
	} pick_t;

	// Tracks the rectangle table and registers, predicts each query answer
	class focus_board;
		box_t       rects[MAX_WINDOWS];
		bit         rel_center;
		logic [4:0] win_cnt;
		pick_t      pending_picks[$];
		int         mismatches;

		function new();
			rel_center = 1'b0;
			win_cnt = '0;
			mismatches = 0;
			foreach (rects[i]) rects[i] = '0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_MODE)
				rel_center = data[0];
			else if (idx == REG_COUNT)
				win_cnt = data;
		endfunction

		function int mid_x(box_t b);
			return int'(b.x) + int'(b.w) / 2;
		endfunction

		function int mid_y(box_t b);
			return int'(b.y) + int'(b.h) / 2;
		endfunction

		// Edge of a candidate that travel reaches first
		function int lead_edge(box_t b, dir_t d, bit center);
			if (center)
				return (d == DIR_LEFT || d == DIR_RIGHT) ? mid_x(b) : mid_y(b);
			case (d)
				DIR_LEFT:  return int'(b.x) + int'(b.w);
				DIR_UP:    return int'(b.y) + int'(b.h);
				DIR_RIGHT: return int'(b.x);
				default:   return int'(b.y);
			endcase
		endfunction

		// Edge of the current rectangle that travel leaves behind
		function int trail_edge(box_t b, dir_t d, bit center);
			if (center)
				return (d == DIR_LEFT || d == DIR_RIGHT) ? mid_x(b) : mid_y(b);
			case (d)
				DIR_LEFT:  return int'(b.x);
				DIR_UP:    return int'(b.y);
				DIR_RIGHT: return int'(b.x) + int'(b.w);
				default:   return int'(b.y) + int'(b.h);
			endcase
		endfunction

		function int side_mid(box_t b, dir_t d);
			return (d == DIR_LEFT || d == DIR_RIGHT) ? mid_y(b) : mid_x(b);
		endfunction

		// Nearest qualifying edge first, then closest cross-axis middle, lowest slot on ties
		function bit pick_neighbor(logic [3:0] cur, dir_t d, bit wrap, output logic [3:0] pick);
			int  cnt;
			int  ref_pos;
			int  mid;
			int  best;
			int  best_dist;
			int  n;
			int  gap;
			int  win;
			bit  backward;
			bit  have_best;
			bit  have_win;
			pick = '0;
			cnt = (win_cnt > MAX_WINDOWS) ? MAX_WINDOWS : int'(win_cnt);
			if (cnt == 0 || int'(cur) >= cnt)
				return 1'b0;
			backward = (d == DIR_LEFT || d == DIR_UP);
			ref_pos = trail_edge(rects[cur], d, rel_center);
			mid = side_mid(rects[cur], d);
			have_best = 1'b0;
			best = 0;
			for (int i = 0; i < cnt; i++) begin
				n = lead_edge(rects[i], d, rel_center);
				if (!wrap) begin
					if (backward && (rel_center ? n >= ref_pos : n > ref_pos))
						continue;
					if (!backward && (rel_center ? n <= ref_pos : n < ref_pos))
						continue;
				end
				if (!have_best || (backward ? n > best : n < best)) begin
					best = n;
					have_best = 1'b1;
				end
			end
			if (!have_best)
				return 1'b0;
			have_win = 1'b0;
			best_dist = 0;
			win = 0;
			for (int i = 0; i < cnt; i++) begin
				if (lead_edge(rects[i], d, rel_center) != best)
					continue;
				gap = side_mid(rects[i], d) - mid;
				if (gap < 0)
					gap = -gap;
				if (!have_win || gap < best_dist) begin
					best_dist = gap;
					win = i;
					have_win = 1'b1;
				end
			end
			pick = 4'(win);
			return have_win;
		endfunction

		// Accepted input word: update the table or queue the expected answer
		function void note_word(logic [1:0] f, logic [3:0] s, logic [15:0] xv, logic [15:0] yv,
				logic [14:0] wv, logic [14:0] hv, logic [1:0] d);
			pick_t p;
			case (f)
				FUNC_LOAD: begin
					rects[s] = '{x: xv, y: yv, w: wv, h: hv};
				end
				FUNC_NEXT, FUNC_FIRST: begin
					p.found = pick_neighbor(s, dir_t'(d), f == FUNC_FIRST, p.slot);
					pending_picks.insert(pending_picks.size(), p);
				end
				default: ;
			endcase
		endfunction

		function void flag(string what);
			if (mismatches < 10)
				$display("[%0t] mismatch: %s", $time, what);
			mismatches++;
		endfunction

		function void check_word(logic got_found, logic [3:0] got_slot);
			pick_t p;
			if (pending_picks.size() == 0) begin
				flag($sformatf("unexpected word found=%0d target_slot=%0d", got_found, got_slot));
				return;
			end
			p = pending_picks.pop_front();
			if (got_found !== p.found)
				flag($sformatf("found: expected %0d, got %0d", p.found, got_found));
			if (got_slot !== p.slot)
				flag($sformatf("target_slot: expected %0d, got %0d", p.slot, got_slot));
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  start     = 1'b0;
	logic [1:0]            func      = '0;
	logic [3:0]            slot      = '0;
	logic signed [15:0]    x_pos     = '0;
	logic signed [15:0]    y_pos     = '0;
	logic [14:0]           width     = '0;
	logic [14:0]           height    = '0;
	logic [1:0]            direction = '0;
	logic                  cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  busy;
	logic                  cfg_ready;
	logic                  done;
	logic                  found;
	logic [3:0]            target_slot;

	focus_board board;

	directional_neighbor_select_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.slot        (slot),
		.x_pos       (x_pos),
		.y_pos       (y_pos),
		.width       (width),
		.height      (height),
		.direction   (direction),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.done        (done),
		.found       (found),
		.target_slot (target_slot)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Result monitor: each done strobe is one word
	always @(posedge clk) begin
		if (arst_n && done)
			board.check_word(found, target_slot);
	end

	// Offer one word, with random idle cycles ahead of it, and wait until taken
	task automatic send_word(logic [1:0] f, logic [3:0] s, logic [15:0] xv, logic [15:0] yv,
			logic [14:0] wv, logic [14:0] hv, logic [1:0] d, int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start     <= 1'b1;
		func      <= f;
		slot      <= s;
		x_pos     <= xv;
		y_pos     <= yv;
		width     <= wv;
		height    <= hv;
		direction <= d;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		board.note_word(f, s, xv, yv, wv, hv, d);
	endtask

	// Drain: all answers in, block idle, then let a full query time pass
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (board.pending_picks.size() != 0 || busy)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_regs(logic mode, logic [4:0] count);
		settle();
		for (int r = 0; r < 2; r++) begin
			cfg_valid <= 1'b1;
			cfg_index <= (r == 0) ? REG_MODE : REG_COUNT;
			cfg_data  <= (r == 0) ? CFG_DATA_W'(mode) : count;
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			board.write_reg((r == 0) ? REG_MODE : REG_COUNT,
				(r == 0) ? CFG_DATA_W'(mode) : count);
		end
		cfg_valid <= 1'b0;
	endtask

	// Loads: half on a coarse grid so edges and middles tie often
	task automatic random_load(int idle_pct);
		int style;
		int xv;
		int yv;
		int wv;
		int hv;
		style = $urandom_range(99);
		if (style < 50) begin
			xv = $urandom_range(7) * 64 - 256;
			yv = $urandom_range(7) * 64 - 256;
			wv = $urandom_range(4) * 64;
			hv = $urandom_range(4) * 64;
		end else if (style < 85) begin
			xv = $urandom_range(2000) - 1000;
			yv = $urandom_range(2000) - 1000;
			wv = $urandom_range(600);
			hv = $urandom_range(600);
		end else begin
			xv = ($urandom_range(3) == 0) ? (($urandom_range(1) == 0) ? -32768 : 32767) : $urandom;
			yv = ($urandom_range(3) == 0) ? (($urandom_range(1) == 0) ? -32768 : 32767) : $urandom;
			wv = ($urandom_range(3) == 0) ? 32767 : $urandom;
			hv = ($urandom_range(3) == 0) ? 32767 : $urandom;
		end
		send_word(FUNC_LOAD, 4'($urandom_range(15)), 16'(xv), 16'(yv), 15'(wv), 15'(hv),
			2'($urandom_range(3)), idle_pct);
	endtask

	// Queries: mostly from a slot inside the table
	task automatic random_query(int idle_pct);
		int cnt_eff;
		int s;
		cnt_eff = (board.win_cnt > MAX_WINDOWS) ? MAX_WINDOWS : int'(board.win_cnt);
		if (cnt_eff > 0 && $urandom_range(9) < 8)
			s = $urandom_range(cnt_eff - 1);
		else
			s = $urandom_range(15);
		send_word(($urandom_range(3) == 0) ? FUNC_FIRST : FUNC_NEXT, 4'(s),
			16'($urandom), 16'($urandom), 15'($urandom), 15'($urandom),
			2'($urandom_range(3)), idle_pct);
	endtask

	task automatic run_phase(int n_items, int idle_pct);
		int sent;
		int roll;
		sent = 0;
		while (sent < n_items) begin
			roll = $urandom_range(99);
			if (roll < 5) begin
				send_word(FUNC_NOP, 4'($urandom_range(15)), 16'($urandom), 16'($urandom),
					15'($urandom), 15'($urandom), 2'($urandom_range(3)), idle_pct);
			end else begin
				if (roll < 30)
					random_load(idle_pct);
				else
					random_query(idle_pct);
				sent++;
			end
		end
	endtask

	initial begin
		#RUN_LIMIT_NS;
		$display("simulation failed");
		$finish;
	end

	initial begin
		int counts[12];
		int idle_levels[3];
		counts = '{16, 16, 4, 31, 1, 2, 0, 9, 17, 16, 12, 16};
		idle_levels = '{0, 76, 7};
		board = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table after reset, plus a dropped func 3 word
		send_word(FUNC_NEXT, 4'd0, 16'h0, 16'h0, 15'h0, 15'h0, DIR_LEFT, 0);
		send_word(FUNC_NOP, 4'hf, 16'hffff, 16'hffff, 15'h7fff, 15'h7fff, DIR_DOWN, 0);

		// Fill every slot: 4x4 grid with both coordinate extremes at the corners
		for (int i = 0; i < MAX_WINDOWS; i++) begin
			if (i == 0)
				send_word(FUNC_LOAD, 4'd0, 16'h8000, 16'h8000, 15'd0, 15'd0, DIR_LEFT, 0);
			else if (i == MAX_WINDOWS - 1)
				send_word(FUNC_LOAD, 4'hf, 16'h7fff, 16'h7fff, 15'h7fff, 15'h7fff, DIR_LEFT, 0);
			else
				send_word(FUNC_LOAD, 4'(i), 16'((i % 4) * 100), 16'((i / 4) * 100),
					15'd80, 15'd80, DIR_LEFT, 0);
		end

		// Border mode: every direction, then wrap both ways
		set_regs(1'b0, 5'd16);
		for (int d = 0; d < 4; d++)
			send_word(FUNC_NEXT, 4'd5, 16'($urandom), 16'($urandom), 15'($urandom),
				15'($urandom), 2'(d), 0);
		send_word(FUNC_FIRST, 4'd5, 16'h0, 16'h0, 15'h0, 15'h0, DIR_LEFT, 0);
		send_word(FUNC_FIRST, 4'd5, 16'h0, 16'h0, 15'h0, 15'h0, DIR_RIGHT, 0);

		// Center mode with an oversized count
		set_regs(1'b1, 5'd31);
		send_word(FUNC_NEXT, 4'd5, 16'h0, 16'h0, 15'h0, 15'h0, DIR_RIGHT, 0);
		send_word(FUNC_NEXT, 4'd0, 16'h0, 16'h0, 15'h0, 15'h0, DIR_UP, 0);

		// Current slot beyond the table
		set_regs(1'b1, 5'd3);
		send_word(FUNC_NEXT, 4'd9, 16'h0, 16'h0, 15'h0, 15'h0, DIR_DOWN, 0);

		// Random phases over modes, table sizes and idle levels
		for (int p = 0; p < 12; p++) begin
			set_regs(1'(p % 2), 5'(counts[p]));
			run_phase(155, idle_levels[p % 3]);
		end

		settle();
		if (board.mismatches == 0 && board.pending_picks.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### files.f
hdl/dns_pkg.sv
hdl/dns_ram.sv
hdl/dns_ctrl.sv
hdl/dns_dp.sv
hdl/directional_neighbor_select_core.sv
test/tb_directional_neighbor_select_core.sv
